FILE: src/assert_macros.svh
// Assertion macros for the tracker RTL.
// They sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define KT_ASSERT(lbl, prop, msg)
`define KT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: src/kt_pkg.sv
// Shared types, constants and saturation helpers for the 2D tracker.
// No dependencies.
package kt_pkg;

  localparam int unsigned TRACK_FRAC_BITS = 16;
  localparam int unsigned DT_FRAC_BITS    = 20;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned DT_W            = 24;
  localparam int unsigned OPND_W          = 33;
  localparam int unsigned PROD_W          = 66;
  localparam int unsigned DIVIDEND_W      = 64;
  localparam int unsigned DIVISOR_W       = 33;
  localparam int unsigned DIV_CNT_W       = $clog2(DIVIDEND_W);
  localparam int unsigned SQ_W            = WORD_W + TRACK_FRAC_BITS + 2;
  localparam int unsigned SQ_STEPS        = (SQ_W + 1) / 2;
  localparam int unsigned SQ_CNT_W        = $clog2(SQ_STEPS);

  localparam logic [WORD_W-1:0] PROC_NOISE_RESET = 32'd655;
  localparam logic [WORD_W-1:0] MEAS_NOISE_RESET = 32'd6554;

  localparam logic signed [PROD_W-1:0] WIDE_MAX = (PROD_W'(1) << (WORD_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] WIDE_MIN = -WIDE_MAX - PROD_W'(1);

  typedef enum logic {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } kt_reg_e;

  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_RESTART = 1'b1
  } kt_cmd_e;

  typedef enum logic [2:0] {
    OP_POS,
    OP_VEL,
    OP_PA,
    OP_PB,
    OP_PC
  } kt_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_SUM,
    ST_DMUL,
    ST_DLOAD,
    ST_DWAIT,
    ST_SQLOAD,
    ST_SQRUN,
    ST_SQSTORE,
    ST_OUT
  } kt_state_e;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > WIDE_MAX) begin
      return WIDE_MAX[WORD_W-1:0];
    end else if (v < WIDE_MIN) begin
      return WIDE_MIN[WORD_W-1:0];
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

  function automatic logic signed [WORD_W-1:0] clamp_var(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1]) begin
      return '0;
    end else if (v > WIDE_MAX) begin
      return WIDE_MAX[WORD_W-1:0];
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

FILE: src/kt_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on kt_pkg for operand widths.
module kt_div import kt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/kalman_tracker_2d_const_velocity_top.sv
// 2D constant-velocity tracker, one shared 33x33 multiplier, divider and sqrt sequencer.
// Restart goes straight to output; a first measure only computes the four spreads.
// Later measures also predict and update each axis, running the divider up to five times
// per axis, then compute the spreads. One request at a time.
// Async active-low reset clears the sequencer and track flag and loads the noise registers with their defaults.
`include "assert_macros.svh"
module kalman_tracker_2d_const_velocity_top import kt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [WORD_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic signed [WORD_W-1:0] meas_x_i,
  input  logic signed [WORD_W-1:0] meas_y_i,
  input  logic [DT_W-1:0]          step_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] position_x_o,
  output logic signed [WORD_W-1:0] position_y_o,
  output logic signed [WORD_W-1:0] velocity_x_o,
  output logic signed [WORD_W-1:0] velocity_y_o,
  output logic [WORD_W-1:0]        spread_pos_x_o,
  output logic [WORD_W-1:0]        spread_pos_y_o,
  output logic [WORD_W-1:0]        spread_vel_x_o,
  output logic [WORD_W-1:0]        spread_vel_y_o
);

  localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) << TRACK_FRAC_BITS;

  kt_state_e state_q, state_d;
  kt_op_e    op_q;
  logic      axis_q;
  logic      found_q;
  logic      out_valid_q;
  logic [WORD_W-1:0] proc_noise_q, meas_noise_q;

  logic signed [WORD_W-1:0] z_q [2];
  logic [DT_W-1:0]          dt_q;
  logic signed [WORD_W-1:0] pos_q [2];
  logic signed [WORD_W-1:0] vel_q [2];
  logic signed [WORD_W-1:0] pa_q [2];
  logic signed [WORD_W-1:0] pb_q [2];
  logic signed [WORD_W-1:0] pc_q [2];
  logic signed [WORD_W-1:0] rep_p_q [2];
  logic signed [WORD_W-1:0] rep_v_q [2];
  logic [WORD_W-1:0]        spread_q [4];

  logic signed [WORD_W-1:0] pp_q, bd_q, cd_q, cdd_q, ap_q, bp_q, cp_q;
  logic [OPND_W-1:0]        s_q;
  logic signed [OPND_W-1:0] innov_q;
  logic                     neg_q;

  logic signed [OPND_W-1:0] mul_a, mul_b, dt_ext, r_ext;
  logic signed [PROD_W-1:0] prod_q, prod_rnd, prod_sh, prod_mag;
  logic signed [PROD_W-1:0] q_ext, w_ap, qs;
  logic signed [WORD_W-1:0] ap_n, bp_n, cp_n;
  logic [OPND_W-1:0]        s_n;
  logic [DIVISOR_W:0]       qc;

  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] div_dividend, div_quo;

  logic [SQ_W-1:0]     sq_val_q, sq_res_q, sq_bit_q, sq_trial;
  logic [SQ_CNT_W-1:0] sq_cnt_q;
  logic [1:0]          sq_idx_q;
  logic [WORD_W-1:0]   sq_var;

  logic in_acc, out_load;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = state_q == ST_OUT && (!out_valid_q || !out_stall_i);

  assign dt_ext   = $signed({{(OPND_W - DT_W){1'b0}}, dt_q});
  assign r_ext    = $signed({1'b0, meas_noise_q});
  assign q_ext    = $signed(PROD_W'(proc_noise_q));
  assign prod_rnd = prod_q + $signed(PROD_W'(1) << (DT_FRAC_BITS - 1));
  assign prod_sh  = prod_rnd >>> DT_FRAC_BITS;
  assign prod_mag = prod_q[PROD_W-1] ? -prod_q : prod_q;

  assign w_ap = PROD_W'(pa_q[axis_q]) + (PROD_W'(bd_q) <<< 1) + PROD_W'(cdd_q) + q_ext;
  assign ap_n = clamp_var(w_ap);
  assign bp_n = sat32(PROD_W'(pb_q[axis_q]) + PROD_W'(cd_q));
  assign cp_n = clamp_var(PROD_W'(pc_q[axis_q]) + q_ext);
  assign s_n  = {1'b0, ap_n} + {1'b0, meas_noise_q};

  assign div_dividend = prod_mag[DIVIDEND_W-1:0] + DIVIDEND_W'(s_q[OPND_W-1:1]);
  // quotient magnitude of 2^34 or more clipped to 2^33, already far beyond any saturated result
  assign qc = (|div_quo[DIVIDEND_W-1:DIVISOR_W+1]) ? (DIVISOR_W + 1)'(1) << DIVISOR_W
                                                    : div_quo[DIVISOR_W:0];
  assign qs = neg_q ? -$signed(PROD_W'(qc)) : $signed(PROD_W'(qc));

  assign sq_trial = sq_res_q + sq_bit_q;

  always_comb begin
    unique case (sq_idx_q)
      2'd0:    sq_var = pa_q[0];
      2'd1:    sq_var = pa_q[1];
      2'd2:    sq_var = pc_q[0];
      default: sq_var = pc_q[1];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M0: begin mul_a = OPND_W'(vel_q[axis_q]); mul_b = dt_ext; end
      ST_M1: begin mul_a = OPND_W'(pb_q[axis_q]);  mul_b = dt_ext; end
      ST_M2: begin mul_a = OPND_W'(pc_q[axis_q]);  mul_b = dt_ext; end
      ST_M4: begin mul_a = OPND_W'(cd_q);          mul_b = dt_ext; end
      ST_DMUL: begin
        unique case (op_q)
          OP_POS:  begin mul_a = OPND_W'(ap_q); mul_b = innov_q; end
          OP_VEL:  begin mul_a = OPND_W'(bp_q); mul_b = innov_q; end
          OP_PA:   begin mul_a = OPND_W'(ap_q); mul_b = r_ext; end
          OP_PB:   begin mul_a = OPND_W'(bp_q); mul_b = r_ext; end
          OP_PC:   begin mul_a = OPND_W'(bp_q); mul_b = OPND_W'(bp_q); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  kt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (s_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_RESTART) begin
            state_d = ST_OUT;
          end else if (!found_q) begin
            state_d = ST_SQLOAD;
          end else begin
            state_d = ST_M0;
          end
        end
      end
      ST_M0:  state_d = ST_M1;
      ST_M1:  state_d = ST_M2;
      ST_M2:  state_d = ST_M3;
      ST_M3:  state_d = ST_M4;
      ST_M4:  state_d = ST_M5;
      ST_M5:  state_d = ST_SUM;
      ST_SUM: begin
        if (s_n == '0) begin
          state_d = axis_q ? ST_SQLOAD : ST_M0;
        end else begin
          state_d = ST_DMUL;
        end
      end
      ST_DMUL: state_d = ST_DLOAD;
      ST_DLOAD: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          if (op_q == OP_PC) begin
            state_d = axis_q ? ST_SQLOAD : ST_M0;
          end else begin
            state_d = ST_DMUL;
          end
        end
      end
      ST_SQLOAD: state_d = ST_SQRUN;
      ST_SQRUN: begin
        if (sq_cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) state_d = ST_SQSTORE;
      end
      ST_SQSTORE: state_d = (sq_idx_q == 2'd3) ? ST_OUT : ST_SQLOAD;
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_POS;
      axis_q       <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      proc_noise_q <= PROC_NOISE_RESET;
      meas_noise_q <= MEAS_NOISE_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROCESS_NOISE:     proc_noise_q <= cfg_data_i;
          REG_MEASUREMENT_NOISE: meas_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        axis_q  <= 1'b0;
        found_q <= command_i != CMD_RESTART;
      end
      if (state_q == ST_SUM) begin
        op_q <= OP_POS;
        if (s_n == '0) axis_q <= 1'b1;
      end
      if (state_q == ST_DWAIT && div_done) begin
        unique case (op_q)
          OP_POS:  op_q <= OP_VEL;
          OP_VEL:  op_q <= OP_PA;
          OP_PA:   op_q <= OP_PB;
          OP_PB:   op_q <= OP_PC;
          default: begin
            op_q   <= OP_POS;
            axis_q <= 1'b1;
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          z_q[0] <= meas_x_i;
          z_q[1] <= meas_y_i;
          dt_q   <= step_time_i;
          if (command_i == CMD_RESTART) begin
            for (int k = 0; k < 2; k++) begin
              rep_p_q[k] <= '0;
              rep_v_q[k] <= '0;
            end
            for (int k = 0; k < 4; k++) spread_q[k] <= '0;
          end else if (!found_q) begin
            pos_q[0]   <= meas_x_i;
            pos_q[1]   <= meas_y_i;
            rep_p_q[0] <= meas_x_i;
            rep_p_q[1] <= meas_y_i;
            sq_idx_q   <= 2'd0;
            for (int k = 0; k < 2; k++) begin
              vel_q[k]   <= '0;
              rep_v_q[k] <= '0;
              pa_q[k]    <= ONE;
              pb_q[k]    <= '0;
              pc_q[k]    <= ONE;
            end
          end
        end
      end
      ST_M0: rep_v_q[axis_q] <= vel_q[axis_q];
      ST_M1: pp_q <= sat32(PROD_W'(pos_q[axis_q]) + prod_sh);
      ST_M2: bd_q <= sat32(prod_sh);
      ST_M3: cd_q <= sat32(prod_sh);
      ST_M5: cdd_q <= sat32(prod_sh);
      ST_SUM: begin
        rep_p_q[axis_q] <= pp_q;
        ap_q    <= ap_n;
        bp_q    <= bp_n;
        cp_q    <= cp_n;
        s_q     <= s_n;
        innov_q <= OPND_W'(z_q[axis_q]) - OPND_W'(pp_q);
        sq_idx_q <= 2'd0;
        if (s_n == '0) begin
          pos_q[axis_q] <= pp_q;
          pa_q[axis_q]  <= ap_n;
          pb_q[axis_q]  <= bp_n;
          pc_q[axis_q]  <= cp_n;
        end
      end
      ST_DLOAD: neg_q <= prod_q[PROD_W-1];
      ST_DWAIT: begin
        if (div_done) begin
          unique case (op_q)
            OP_POS:  pos_q[axis_q] <= sat32(PROD_W'(pp_q) + qs);
            OP_VEL:  vel_q[axis_q] <= sat32(PROD_W'(vel_q[axis_q]) + qs);
            OP_PA:   pa_q[axis_q]  <= clamp_var(qs);
            OP_PB:   pb_q[axis_q]  <= sat32(qs);
            default: pc_q[axis_q]  <= clamp_var(PROD_W'(cp_q) - qs);
          endcase
        end
      end
      ST_SQLOAD: begin
        sq_val_q <= {sq_var, {(TRACK_FRAC_BITS + 2){1'b0}}};
        sq_res_q <= '0;
        sq_bit_q <= SQ_W'(1) << (2 * (SQ_STEPS - 1));
        sq_cnt_q <= '0;
      end
      ST_SQRUN: begin
        if (sq_val_q >= sq_trial) begin
          sq_val_q <= sq_val_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
      end
      ST_SQSTORE: begin
        spread_q[sq_idx_q] <= (|sq_res_q[SQ_W-1:WORD_W]) ? '1 : sq_res_q[WORD_W-1:0];
        sq_idx_q <= sq_idx_q + 2'd1;
      end
      ST_OUT: begin
        if (out_load) begin
          position_x_o   <= rep_p_q[0];
          position_y_o   <= rep_p_q[1];
          velocity_x_o   <= rep_v_q[0];
          velocity_y_o   <= rep_v_q[1];
          spread_pos_x_o <= spread_q[0];
          spread_pos_y_o <= spread_q[1];
          spread_vel_x_o <= spread_q[2];
          spread_vel_y_o <= spread_q[3];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `KT_ASSERT(a_div_done_in_wait, div_done |-> state_q == ST_DWAIT, "divider finished outside wait")
  `KT_ASSERT_NEVER(a_div_zero, state_q == ST_DMUL && s_q == '0, "division by zero variance")
  `KT_ASSERT(a_sqrt_needs_track, state_q == ST_SQLOAD |-> found_q, "spread without a track")

endmodule
